// ===== src/subtask_dependency_dispatcher_defines.svh =====
// Assertion macros shared by the dependency dispatcher RTL.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef SUBTASK_DEPENDENCY_DISPATCHER_DEFINES_SVH
`define SUBTASK_DEPENDENCY_DISPATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define SDD_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SDD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define SDD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define SDD_ASSERT_ALWAYS(name, expr)
`define SDD_ASSERT_IMP(name, ante, cons)
`define SDD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== src/sdd_pkg.sv =====
// Shared types, widths, command codes and mask helpers of the dependency dispatcher.
// No dependencies; every other file of the block but the macro header refers to it by scoped names.
package sdd_pkg;

  localparam int NODE_W = 5;
  localparam int ROW_W  = 32;
  localparam int CNT_W  = 6;
  localparam int CODE_W = 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_DONE  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  // Mask with the low count bits set; a count of 32 or more sets all bits.
  function automatic logic [ROW_W-1:0] graph_mask(input logic [CNT_W-1:0] count);
    logic [ROW_W:0] wide;
    wide = ({{ROW_W{1'b0}}, 1'b1} << count) - {{ROW_W{1'b0}}, 1'b1};
    if (count >= CNT_W'(ROW_W)) begin
      return '1;
    end
    return wide[ROW_W-1:0];
  endfunction

  // Index of the single set bit of a one-hot word.
  function automatic logic [NODE_W-1:0] onehot_index(input logic [ROW_W-1:0] oh);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (oh[i]) begin
        idx = idx | NODE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/sdd_if.sv =====
// Handshake channel interfaces for the dependency dispatcher: command words in, results out.
// Depends on sdd_pkg for field widths.
interface sdd_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [sdd_pkg::NODE_W-1:0] node_index;
  logic [sdd_pkg::ROW_W-1:0]  row_bits;
  logic [sdd_pkg::CNT_W-1:0]  node_count;
  logic [sdd_pkg::CODE_W-1:0] return_code;

  modport source (output valid, command, node_index, row_bits, node_count, return_code,
                  input ready);
  modport sink   (input valid, command, node_index, row_bits, node_count, return_code,
                  output ready);
endinterface

interface sdd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [sdd_pkg::NODE_W-1:0] dispatch_index;
  logic [sdd_pkg::CODE_W-1:0] final_code;
  logic                       last;

  modport source (output valid, kind, dispatch_index, final_code, last, input ready);
  modport sink   (input valid, kind, dispatch_index, final_code, last, output ready);
endinterface

// ===== src/sdd_row_mem.sv =====
// Adjacency row store: one write port and one read port with registered read data.
// Depends on sdd_pkg for the row width.
module sdd_row_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [sdd_pkg::ROW_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [sdd_pkg::ROW_W-1:0] rd_data
);

  logic [sdd_pkg::ROW_W-1:0] mem_r [DEPTH];
  logic [sdd_pkg::ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/subtask_dependency_dispatcher.sv =====
// Top level of the task graph dependency scoreboard and dispatcher.
// Depends on sdd_pkg, sdd_in_if/sdd_out_if, sdd_row_mem and the assertion macro header.
//
//   channel  | direction | word
//   in_ch    | in        | command, node_index, row_bits, node_count, return_code
//   out_ch   | out       | kind, dispatch_index, final_code, last
//
// A load word is taken in the idle state. A start or done word is accepted, then the row
// memory is read one row per cycle over the N active rows (N is the active node count),
// the ready set is formed and results, if any, leave one per cycle while out_ch has room.
// The single read port of the row memory sets the length of the sweep.
// Reset (rst_n low, synchronous) clears the pending, outstanding and graph masks, the accumulator
// and the node count; rows hold nothing defined until loaded. A stalled out_ch holds S_EMIT.
`include "subtask_dependency_dispatcher_defines.svh"

module subtask_dependency_dispatcher #(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  sdd_in_if.sink      in_ch,
  sdd_out_if.source   out_ch
);

  localparam int DEPTH = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_READY,
    S_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [sdd_pkg::ROW_W-1:0]   pend_r, pend_nxt;
  logic [sdd_pkg::ROW_W-1:0]   outst_r, outst_nxt;
  logic [sdd_pkg::CODE_W-1:0]  acc_r, acc_nxt;
  logic [sdd_pkg::CNT_W-1:0]   active_r, active_nxt;
  logic [sdd_pkg::ROW_W-1:0]   gmask_r, gmask_nxt;
  logic [sdd_pkg::ROW_W-1:0]   cols_r, cols_nxt;
  logic [sdd_pkg::ROW_W-1:0]   rdy_set_r, rdy_set_nxt;
  logic [sdd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic                        is_start_r, is_start_nxt;
  logic                        cpl_r, cpl_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_kind_r, out_kind_nxt;
  logic [sdd_pkg::NODE_W-1:0]  out_idx_r, out_idx_nxt;
  logic [sdd_pkg::CODE_W-1:0]  out_code_r, out_code_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [sdd_pkg::ROW_W-1:0]   mem_wd;
  logic                        mem_re;
  logic [sdd_pkg::ROW_W-1:0]   mem_rd;

  sdd_pkg::cmd_t               cmd;
  logic [sdd_pkg::CNT_W-1:0]   count_sat;
  logic [sdd_pkg::ROW_W-1:0]   node_bit;
  logic                        node_in_mem;
  logic                        retired;
  logic                        slot_free;
  logic [sdd_pkg::ROW_W-1:0]   low_bit;
  logic [sdd_pkg::ROW_W-1:0]   rdy_rem;

  assign cmd         = sdd_pkg::cmd_t'(in_ch.command);
  assign node_bit    = {{(sdd_pkg::ROW_W-1){1'b0}}, 1'b1} << in_ch.node_index;
  assign node_in_mem = {1'b0, in_ch.node_index} < sdd_pkg::CNT_W'(DEPTH);
  assign retired     = |(outst_r & node_bit);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign low_bit     = rdy_set_r & (~rdy_set_r + {{(sdd_pkg::ROW_W-1){1'b0}}, 1'b1});
  assign rdy_rem     = is_start_r ? (rdy_set_r & ~low_bit) : '0;

  // A zero count means one node; larger counts saturate to the row store depth.
  always_comb begin
    if (in_ch.node_count == '0) begin
      count_sat = sdd_pkg::CNT_W'(1);
    end else if (in_ch.node_count > sdd_pkg::CNT_W'(DEPTH)) begin
      count_sat = sdd_pkg::CNT_W'(DEPTH);
    end else begin
      count_sat = in_ch.node_count;
    end
  end

  sdd_row_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_rows (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (mem_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    outst_nxt     = outst_r;
    acc_nxt       = acc_r;
    active_nxt    = active_r;
    gmask_nxt     = gmask_r;
    cols_nxt      = cols_r;
    rdy_set_nxt   = rdy_set_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = rd_vld_r;
    is_start_nxt  = is_start_r;
    cpl_nxt       = cpl_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = in_ch.node_index[AW-1:0];
    mem_wd        = in_ch.row_bits;
    mem_re        = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (cmd)
            sdd_pkg::CMD_LOAD: begin
              mem_we = node_in_mem;
            end
            sdd_pkg::CMD_START: begin
              active_nxt   = count_sat;
              gmask_nxt    = sdd_pkg::graph_mask(count_sat);
              pend_nxt     = sdd_pkg::graph_mask(count_sat);
              outst_nxt    = sdd_pkg::graph_mask(count_sat);
              acc_nxt      = '0;
              is_start_nxt = 1'b1;
              cpl_nxt      = 1'b0;
              cols_nxt     = '0;
              cnt_nxt      = '0;
              rd_vld_nxt   = 1'b0;
              state_nxt    = S_SWEEP;
            end
            sdd_pkg::CMD_DONE: begin
              // Retiring a node clears its row so later sweeps see it released.
              if (retired) begin
                outst_nxt = outst_r & ~node_bit;
                mem_we    = 1'b1;
                mem_wd    = '0;
                acc_nxt   = acc_r | in_ch.return_code;
              end
              cpl_nxt      = retired && ((outst_r & ~node_bit) == '0);
              is_start_nxt = 1'b0;
              cols_nxt     = '0;
              cnt_nxt      = '0;
              rd_vld_nxt   = 1'b0;
              state_nxt    = S_SWEEP;
            end
            sdd_pkg::CMD_RSVD: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        // Read data is registered and arrives in the cycle after its address, so the fold runs one row behind.
        if (rd_vld_r) begin
          cols_nxt = cols_r | mem_rd;
        end
        if (cnt_r < active_r) begin
          mem_re     = 1'b1;
          cnt_nxt    = cnt_r + sdd_pkg::CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          state_nxt  = S_READY;
        end
      end
      S_READY: begin
        rdy_set_nxt = pend_r & ~cols_r & gmask_r;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          if (rdy_set_r != '0) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = sdd_pkg::KIND_DISPATCH;
            out_idx_nxt   = sdd_pkg::onehot_index(low_bit);
            out_code_nxt  = '0;
            out_last_nxt  = (rdy_rem == '0) && !cpl_r;
            pend_nxt      = pend_r & ~low_bit;
            rdy_set_nxt   = rdy_rem;
            if ((rdy_rem == '0) && !cpl_r) begin
              state_nxt = S_IDLE;
            end
          end else if (cpl_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = sdd_pkg::KIND_COMPLETE;
            out_idx_nxt   = '0;
            out_code_nxt  = acc_r;
            out_last_nxt  = 1'b1;
            cpl_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      outst_r     <= '0;
      acc_r       <= '0;
      active_r    <= '0;
      gmask_r     <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      is_start_r  <= 1'b0;
      cpl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      outst_r     <= outst_nxt;
      acc_r       <= acc_nxt;
      active_r    <= active_nxt;
      gmask_r     <= gmask_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      is_start_r  <= is_start_nxt;
      cpl_r       <= cpl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cols_r     <= cols_nxt;
    rdy_set_r  <= rdy_set_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.dispatch_index = out_idx_r;
  assign out_ch.final_code     = out_code_r;
  assign out_ch.last           = out_last_r;

  `SDD_ASSERT_ALWAYS(a_pend_in_graph, (pend_r & ~gmask_r) == '0)
  `SDD_ASSERT_ALWAYS(a_sweep_bound, cnt_r <= active_r)
  `SDD_ASSERT_IMP(a_complete_is_last, out_valid_r && out_kind_r, out_last_r && out_idx_r == '0)
  `SDD_ASSERT_IMP(a_dispatch_no_code, out_valid_r && !out_kind_r, out_code_r == '0)
  `SDD_ASSERT_NEXT(a_work_starts_sweep, in_ch.valid && in_ch.ready && (cmd == sdd_pkg::CMD_START || cmd == sdd_pkg::CMD_DONE), state_r == S_SWEEP && cnt_r == '0)

endmodule

// ===== test/sdd_checker.sv =====
// Scoreboard for the subtask dependency dispatcher: predicts the result words of every
// accepted command word and compares them field by field. Depends on sdd_pkg and sdd_if.
module sdd_checker #(
  parameter int MAX_NODES = 32
) (
  input  logic clk,
  input  logic rst_n,
  sdd_in_if    in_mon,
  sdd_out_if   out_mon,
  output int   fail_count,
  output int   expected_left,
  output int   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_CAP = (MAX_NODES < sdd_pkg::ROW_W) ? MAX_NODES : sdd_pkg::ROW_W;

  typedef struct packed {
    logic                       kind;
    logic [sdd_pkg::NODE_W-1:0] node;
    logic [sdd_pkg::CODE_W-1:0] code;
    logic                       last;
  } sched_result_t;

  sched_result_t    expected_results[$];
  sched_result_t    staged;
  bit               staged_ok;

  logic [sdd_pkg::ROW_W-1:0]  dep_rows [sdd_pkg::ROW_W];
  logic [sdd_pkg::ROW_W-1:0]  waiting_nodes;
  logic [sdd_pkg::ROW_W-1:0]  live_nodes;
  logic [sdd_pkg::CODE_W-1:0] or_code;
  logic [sdd_pkg::CNT_W-1:0]  graph_size;

  function automatic logic [sdd_pkg::ROW_W-1:0] span_of(input logic [sdd_pkg::CNT_W-1:0] n);
    logic [sdd_pkg::ROW_W-1:0] m;
    m = '0;
    for (int i = 0; i < sdd_pkg::ROW_W; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  // A node can go once no row of the current graph names it.
  function automatic logic [sdd_pkg::ROW_W-1:0] ready_nodes();
    logic [sdd_pkg::ROW_W-1:0] blocked;
    blocked = '0;
    for (int i = 0; i < sdd_pkg::ROW_W; i++) begin
      if (i < graph_size) blocked |= dep_rows[i];
    end
    return waiting_nodes & ~blocked & span_of(graph_size);
  endfunction

  // Holds back one result so that the final one of a word can be marked last.
  task automatic stage_result(input logic kind, input logic [sdd_pkg::NODE_W-1:0] node,
                              input logic [sdd_pkg::CODE_W-1:0] code);
    if (staged_ok) expected_results.push_back(staged);
    staged.kind = kind;
    staged.node = node;
    staged.code = code;
    staged.last = 1'b0;
    staged_ok = 1'b1;
  endtask

  task automatic predict_word(input logic [1:0] cmd, input logic [sdd_pkg::NODE_W-1:0] node,
                              input logic [sdd_pkg::ROW_W-1:0] row,
                              input logic [sdd_pkg::CNT_W-1:0] count,
                              input logic [sdd_pkg::CODE_W-1:0] code);
    logic [sdd_pkg::ROW_W-1:0] free;
    logic [sdd_pkg::CNT_W-1:0] n;
    bit                        retired;
    staged_ok = 1'b0;
    case (cmd)
      sdd_pkg::CMD_LOAD: begin
        dep_rows[node] = row;
      end
      sdd_pkg::CMD_START: begin
        n = (count == '0) ? sdd_pkg::CNT_W'(1) : count;
        if (n > NODE_CAP) n = sdd_pkg::CNT_W'(NODE_CAP);
        graph_size    = n;
        waiting_nodes = span_of(n);
        live_nodes    = waiting_nodes;
        or_code       = '0;
        free = ready_nodes();
        for (int i = 0; i < sdd_pkg::ROW_W; i++) begin
          if (free[i]) stage_result(sdd_pkg::KIND_DISPATCH, sdd_pkg::NODE_W'(i), '0);
        end
        waiting_nodes &= ~free;
      end
      sdd_pkg::CMD_DONE: begin
        retired = live_nodes[node];
        if (retired) begin
          live_nodes[node] = 1'b0;
          dep_rows[node]   = '0;
          or_code         |= code;
        end
        free = ready_nodes();
        for (int i = 0; i < sdd_pkg::ROW_W; i++) begin
          if (free[i]) begin
            stage_result(sdd_pkg::KIND_DISPATCH, sdd_pkg::NODE_W'(i), '0);
            waiting_nodes[i] = 1'b0;
            break;
          end
        end
        if (retired && live_nodes == '0) stage_result(sdd_pkg::KIND_COMPLETE, '0, or_code);
      end
      default: ;
    endcase
    if (staged_ok) begin
      staged.last = 1'b1;
      expected_results.push_back(staged);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [sdd_pkg::CODE_W-1:0] got,
                                 input logic [sdd_pkg::CODE_W-1:0] want);
    fail_count++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result();
    sched_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("result word with nothing expected, final_code", out_mon.final_code,
                      '0);
    end else begin
      want = expected_results.pop_front();
      if (out_mon.kind !== want.kind)
        report_mismatch("kind", sdd_pkg::CODE_W'(out_mon.kind), sdd_pkg::CODE_W'(want.kind));
      if (out_mon.dispatch_index !== want.node)
        report_mismatch("dispatch_index", sdd_pkg::CODE_W'(out_mon.dispatch_index),
                        sdd_pkg::CODE_W'(want.node));
      if (out_mon.final_code !== want.code)
        report_mismatch("final_code", out_mon.final_code, want.code);
      if (out_mon.last !== want.last)
        report_mismatch("last", sdd_pkg::CODE_W'(out_mon.last), sdd_pkg::CODE_W'(want.last));
    end
  endtask

  // Results leaving at an edge always belong to earlier words, so check before predicting.
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < sdd_pkg::ROW_W; i++) dep_rows[i] = '0;
      waiting_nodes = '0;
      live_nodes    = '0;
      or_code       = '0;
      graph_size    = '0;
      fail_count    = 0;
      results_seen  = 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_result();
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        predict_word(in_mon.command, in_mon.node_index, in_mon.row_bits, in_mon.node_count,
                     in_mon.return_code);
      end
    end
    expected_left = expected_results.size();
  end

endmodule

// ===== test/tb_subtask_dependency_dispatcher.sv =====
// Top of the dispatcher testbench: clock, reset, command stimulus and output flow control.
// Depends on sdd_pkg, sdd_if, the dispatcher RTL and sdd_checker, which does the checking.
module tb_subtask_dependency_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES       = 32;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int WORDS_PER_PHASE = 117;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 150;

  logic clk;
  logic rst_n;

  sdd_in_if  in_ch();
  sdd_out_if out_ch();

  int fail_count;
  int expected_left;
  int results_seen;

  subtask_dependency_dispatcher #(.MAX_NODES(MAX_NODES)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sdd_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .expected_left(expected_left),
    .results_seen (results_seen)
  );

  int          send_idle;
  int          recv_idle;
  int          hold_left;
  bit          counting;
  int          phase_words;
  int          words_sent;
  int          graphs_finished;
  int          disruptions;
  int          cycle_count;
  logic [31:0] rows_loaded;
  logic [4:0]  running_q[$];
  bit          graph_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever @(posedge clk) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("tb_subtask_dependency_dispatcher: FAIL");
        $finish;
      end
    end
  end

  // Output flow control; a long hold-off counts down here, independent of the sender.
  initial begin
    out_ch.ready = 1'b0;
    forever @(negedge clk) begin
      if (!rst_n) begin
        out_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Dispatched nodes are handed back to the sender so that it can finish them.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (out_ch.kind == sdd_pkg::KIND_DISPATCH) begin
        running_q.push_back(out_ch.dispatch_index);
      end else begin
        graph_done = 1'b1;
        graphs_finished++;
      end
    end
  end

  // Called and returns at a falling edge with valid low.
  task automatic send_word(input logic [1:0] cmd, input logic [4:0] node,
                           input logic [31:0] row, input logic [5:0] count,
                           input logic [31:0] code);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_ch.command     = cmd;
    in_ch.node_index  = node;
    in_ch.row_bits    = row;
    in_ch.node_count  = count;
    in_ch.return_code = code;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
    if (cmd == sdd_pkg::CMD_LOAD) rows_loaded[node] = 1'b1;
    words_sent++;
    if (counting && cmd != sdd_pkg::CMD_RSVD) phase_words++;
  endtask

  task automatic drain();
    while (expected_left != 0) @(negedge clk);
  endtask

  // A start reads the rows of every node in its graph, so none may be left unwritten.
  task automatic ensure_rows(input logic [5:0] count);
    int span;
    span = (count == 0) ? 1 : ((count > 32) ? 32 : count);
    for (int i = 0; i < span; i++) begin
      if (!rows_loaded[i]) begin
        send_word(sdd_pkg::CMD_LOAD, 5'(i), $urandom(), 6'($urandom()), $urandom());
      end
    end
  endtask

  function automatic logic [31:0] return_value();
    return ($urandom_range(3) == 0) ? $urandom() : (32'h1 << $urandom_range(31));
  endfunction

  // Edges only point to higher nodes, so the graph is acyclic and node 0 is always ready.
  function automatic logic [31:0] dag_row(input int i);
    logic [32:0] low;
    logic [31:0] bits;
    low  = (33'h1 << (i + 1)) - 33'h1;
    bits = ($urandom_range(1) == 0) ? $urandom() : ($urandom() & $urandom());
    return bits & ~low[31:0];
  endfunction

  task automatic send_noise();
    logic [1:0] cmd;
    logic [5:0] count;
    cmd   = 2'($urandom_range(3));
    count = 6'($urandom_range(63));
    if (cmd == sdd_pkg::CMD_START) ensure_rows(count);
    send_word(cmd, 5'($urandom()), $urandom(), count, $urandom());
    disruptions++;
  endtask

  task automatic disrupt(output bit abandoned);
    logic [5:0] count;
    abandoned = 1'b0;
    disruptions++;
    case ($urandom_range(2))
      0: send_word(sdd_pkg::CMD_DONE, 5'($urandom()), $urandom(), 6'($urandom()),
                   return_value());
      1: send_word(sdd_pkg::CMD_LOAD, 5'($urandom()), $urandom(), 6'($urandom()), $urandom());
      default: begin
        count = 6'($urandom_range(63));
        ensure_rows(count);
        send_word(sdd_pkg::CMD_START, 5'($urandom()), $urandom(), count, $urandom());
        abandoned = 1'b1;
      end
    endcase
  endtask

  task automatic run_graph(input int size);
    logic [4:0] node;
    int         pick;
    bit         abandoned;
    abandoned = 1'b0;
    while ($urandom_range(99) < 15) send_noise();
    drain();
    running_q.delete();
    graph_done = 1'b0;
    for (int i = 0; i < size; i++) begin
      send_word(sdd_pkg::CMD_LOAD, 5'(i), dag_row(i), 6'($urandom()), $urandom());
    end
    send_word(sdd_pkg::CMD_START, 5'($urandom()), $urandom(), 6'(size), $urandom());
    while (!graph_done && !abandoned) begin
      while (running_q.size() == 0 && !graph_done && expected_left != 0) @(negedge clk);
      if (running_q.size() == 0) break;
      pick = $urandom_range(running_q.size() - 1);
      node = running_q[pick];
      running_q.delete(pick);
      if ($urandom_range(99) < 8) disrupt(abandoned);
      if (!abandoned) begin
        send_word(sdd_pkg::CMD_DONE, node, $urandom(), 6'($urandom()), return_value());
      end
    end
  endtask

  function automatic int pick_size();
    return ($urandom_range(7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
  endfunction

  // Full graph of independent nodes while the output is held off, so results back up
  // and the input stalls; afterwards the sender waits for every result.
  task automatic back_pressure();
    drain();
    for (int i = 0; i < 32; i++) begin
      send_word(sdd_pkg::CMD_LOAD, 5'(i), '0, 6'($urandom()), $urandom());
    end
    hold_left = HOLD_CYCLES;
    send_word(sdd_pkg::CMD_START, 5'($urandom()), $urandom(), 6'd32, $urandom());
    repeat (6) send_noise();
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = sdd_pkg::CMD_LOAD;
    in_ch.node_index  = '0;
    in_ch.row_bits    = '0;
    in_ch.node_count  = '0;
    in_ch.return_code = '0;
    send_idle         = 27;
    recv_idle         = 70;
    hold_left         = 0;
    counting          = 1'b0;
    phase_words       = 0;
    words_sent        = 0;
    graphs_finished   = 0;
    disruptions       = 0;
    rows_loaded       = '0;
    graph_done        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reserved command, then a finish with no graph open.
    send_word(sdd_pkg::CMD_RSVD, 5'h1f, 32'hffff_ffff, 6'h3f, 32'hffff_ffff);
    send_word(sdd_pkg::CMD_DONE, 5'd31, 32'h0, 6'd0, 32'hffff_ffff);
    // Nodes 1 and 2 wait on 0, node 3 on 1, node 2 on itself; bit 31 lies outside.
    send_word(sdd_pkg::CMD_LOAD, 5'd0, 32'h0000_0006, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_LOAD, 5'd1, 32'h8000_0008, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_LOAD, 5'd2, 32'h0000_0004, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_LOAD, 5'd3, 32'h0000_0000, 6'd0, 32'h0);
    // A count of zero opens a graph of one node.
    send_word(sdd_pkg::CMD_START, 5'd0, 32'h0, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_DONE, 5'd0, 32'h0, 6'd0, 32'hffff_ffff);
    send_word(sdd_pkg::CMD_LOAD, 5'd0, 32'h0000_0006, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_START, 5'd0, 32'h0, 6'd4, 32'h0);
    // Node 2 finishes before it was dispatched, which also clears its self dependency.
    send_word(sdd_pkg::CMD_DONE, 5'd2, 32'h0, 6'd0, 32'h0000_0001);
    send_word(sdd_pkg::CMD_DONE, 5'd0, 32'h0, 6'd0, 32'h8000_0000);
    // Finish of a node outside the graph still dispatches.
    send_word(sdd_pkg::CMD_DONE, 5'd17, 32'h0, 6'd0, 32'hffff_ffff);
    send_word(sdd_pkg::CMD_DONE, 5'd1, 32'h0, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_DONE, 5'd3, 32'h0, 6'd0, 32'h0000_0002);
    // Last finish releases a node: dispatch and completion from one word.
    send_word(sdd_pkg::CMD_LOAD, 5'd0, 32'h0000_0002, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_START, 5'd0, 32'h0, 6'd2, 32'h0);
    send_word(sdd_pkg::CMD_DONE, 5'd1, 32'h0, 6'd0, 32'h0000_0010);
    send_word(sdd_pkg::CMD_DONE, 5'd0, 32'h0, 6'd0, 32'h0000_0100);
    // A new start drops the graph that is still running.
    send_word(sdd_pkg::CMD_LOAD, 5'd0, 32'h0000_0002, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_START, 5'd0, 32'h0, 6'd2, 32'h0);
    send_word(sdd_pkg::CMD_START, 5'd0, 32'h0, 6'd3, 32'h0);
    send_word(sdd_pkg::CMD_DONE, 5'd0, 32'h0, 6'd0, 32'h5a5a_5a5a);
    send_word(sdd_pkg::CMD_DONE, 5'd1, 32'h0, 6'd0, 32'h0);
    send_word(sdd_pkg::CMD_DONE, 5'd2, 32'h0, 6'd0, 32'h0);
    drain();

    counting = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      phase_words = 0;
      case (phase)
        0: begin
          send_idle = 27;
          recv_idle = 70;
          run_graph(32);
          ensure_rows(6'd63);
          send_word(sdd_pkg::CMD_START, 5'($urandom()), $urandom(), 6'd63, $urandom());
        end
        1: begin
          send_idle = 70;
          recv_idle = 27;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          back_pressure();
        end
      endcase
      while (phase_words < WORDS_PER_PHASE) run_graph(pick_size());
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Covered %0d command words over three idling mixes and a long output stall;",
             words_sent);
    $display("%0d graphs completed, %0d off-protocol words, %0d results compared.",
             graphs_finished, disruptions, results_seen);
    if (fail_count == 0 && expected_left == 0) begin
      $display("tb_subtask_dependency_dispatcher: PASS");
    end else begin
      $display("tb_subtask_dependency_dispatcher: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sdd_pkg.sv
src/sdd_if.sv
src/sdd_row_mem.sv
src/subtask_dependency_dispatcher.sv
test/sdd_checker.sv
test/tb_subtask_dependency_dispatcher.sv
